>>> src/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg - shared types and helpers for the 3x3 matrix inverse
// Fixed-point word type, matrix bundle and 64-to-32 bit saturation.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int FX_W = 32;

	typedef logic signed [FX_W-1:0] fx_t;

	// t: working matrix, w: companion matrix, sing: singular so far
	typedef struct packed {
		logic [0:2][0:2][FX_W-1:0] t;
		logic [0:2][0:2][FX_W-1:0] w;
		logic                      sing;
	} mat_t;

	localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

	function automatic fx_t sat64(input logic signed [63:0] v);
		fx_t r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[FX_W-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[FX_W-1:0];
		end else begin
			r = v[FX_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> src/m3i_div.sv
// ----------------------------------------------------------------------------
// m3i_div - pipelined fixed-point divider
// Computes sat((num << FRAC_BITS) / den), truncated toward zero, zero when
// den is zero. Restoring division, one quotient bit per stage, all lanes in
// lockstep.
// ----------------------------------------------------------------------------
module m3i_div #(
	parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF,
	parameter int LANES     = 1,
	parameter int SIDE_W    = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld,
	input  m3i_pkg::fx_t        num [LANES],
	input  m3i_pkg::fx_t        den [LANES],
	input  logic [SIDE_W-1:0]   side,
	output logic                out_vld,
	output m3i_pkg::fx_t        quo [LANES],
	output logic [SIDE_W-1:0]   out_side
);
	import m3i_pkg::*;

	localparam int NW = FX_W + FRAC_BITS;
	localparam logic [NW-1:0] QMAX = NW'(32'h7fff_ffff);
	localparam logic [NW-1:0] QNEG = NW'(32'h8000_0000);

	logic              vld_q  [0:NW];
	logic [SIDE_W-1:0] side_q [0:NW];
	logic [FX_W-1:0]   rem_q  [0:NW][LANES];
	logic [FX_W-1:0]   dm_q   [0:NW][LANES];
	logic [NW-1:0]     dvd_q  [0:NW][LANES];
	logic [NW-1:0]     quo_q  [0:NW][LANES];
	logic              neg_q  [0:NW][LANES];
	logic              dz_q   [0:NW][LANES];

	logic              vld_o_q;
	logic [SIDE_W-1:0] side_o_q;
	fx_t               quo_o_q [LANES];

	// operand prep: sign/magnitude split
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side;
			for (int l = 0; l < LANES; l++) begin
				logic [FX_W-1:0] nm;
				nm = num[l][FX_W-1] ? FX_W'(-num[l]) : num[l];
				neg_q[0][l] <= num[l][FX_W-1] ^ den[l][FX_W-1];
				dz_q[0][l]  <= (den[l] == '0);
				dm_q[0][l]  <= den[l][FX_W-1] ? FX_W'(-den[l]) : den[l];
				rem_q[0][l] <= '0;
				dvd_q[0][l] <= {nm, {FRAC_BITS{1'b0}}};
				quo_q[0][l] <= '0;
			end
		end
	end

	for (genvar k = 0; k < NW; k++) begin : g_bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else if (en) begin
				vld_q[k+1] <= vld_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[k+1] <= side_q[k];
				for (int l = 0; l < LANES; l++) begin
					logic [FX_W:0] trial;
					logic          ge;
					trial = {rem_q[k][l], dvd_q[k][l][NW-1]};
					ge    = (trial >= {1'b0, dm_q[k][l]});
					rem_q[k+1][l] <= ge ? FX_W'(trial - {1'b0, dm_q[k][l]}) : trial[FX_W-1:0];
					quo_q[k+1][l] <= {quo_q[k][l][NW-2:0], ge};
					dvd_q[k+1][l] <= {dvd_q[k][l][NW-2:0], 1'b0};
					dm_q[k+1][l]  <= dm_q[k][l];
					neg_q[k+1][l] <= neg_q[k][l];
					dz_q[k+1][l]  <= dz_q[k][l];
				end
			end
		end
	end : g_bit

	// sign restore and saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o_q <= 1'b0;
		end else if (en) begin
			vld_o_q <= vld_q[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_o_q <= side_q[NW];
			for (int l = 0; l < LANES; l++) begin
				logic [NW-1:0] qm;
				qm = quo_q[NW][l];
				if (dz_q[NW][l]) begin
					quo_o_q[l] <= '0;
				end else if (!neg_q[NW][l]) begin
					quo_o_q[l] <= (qm > QMAX) ? QMAX[FX_W-1:0] : qm[FX_W-1:0];
				end else begin
					quo_o_q[l] <= (qm > QNEG) ? QNEG[FX_W-1:0] : FX_W'(-qm[FX_W-1:0]);
				end
			end
		end
	end

	assign out_vld  = vld_o_q;
	assign out_side = side_o_q;
	assign quo      = quo_o_q;

endmodule

>>> src/m3i_pivot.sv
// ----------------------------------------------------------------------------
// m3i_pivot - load and row-swap stage
// Builds working and companion matrices and swaps a zero diagonal row with
// the highest-numbered row that is nonzero in that column, column by column.
// ----------------------------------------------------------------------------
module m3i_pivot #(
	parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld,
	input  m3i_pkg::fx_t   a [0:2][0:2],
	output logic           out_vld,
	output m3i_pkg::mat_t  out_mat
);
	import m3i_pkg::*;

	localparam logic [FX_W-1:0] ONE = FX_W'(64'd1 << FRAC_BITS);

	mat_t                  m;
	logic                  found;
	logic [1:0]            pr;
	logic [0:2][FX_W-1:0]  tr;
	logic [0:2][FX_W-1:0]  wr;
	logic                  vld_s1;
	mat_t                  mat_s1;

	always_comb begin
		m     = '0;
		found = 1'b0;
		pr    = '0;
		tr    = '0;
		wr    = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				m.t[r][c] = a[r][c];
				m.w[r][c] = (r == c) ? ONE : '0;
			end
		end
		for (int c = 0; c < 3; c++) begin
			if (m.t[c][c] == '0) begin
				found = 1'b0;
				pr    = '0;
				for (int k = 0; k < 3; k++) begin
					if (m.t[k][c] != '0) begin
						found = 1'b1;
						pr    = 2'(k);
					end
				end
				if (!found) begin
					m.sing = 1'b1;
				end else begin
					tr       = m.t[c];
					wr       = m.w[c];
					m.t[c]   = m.t[pr];
					m.w[c]   = m.w[pr];
					m.t[pr]  = tr;
					m.w[pr]  = wr;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat_s1 <= m;
		end
	end

	assign out_vld = vld_s1;
	assign out_mat = mat_s1;

endmodule

>>> src/m3i_elim.sv
// ----------------------------------------------------------------------------
// m3i_elim - one row elimination
// Factor x = t[a][b] / t[b][b], then row a of both matrices loses
// trunc(x * row b / ONE), saturated. Divider, multiply and subtract stages.
// ----------------------------------------------------------------------------
module m3i_elim #(
	parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF,
	parameter int ROW_A     = 1,
	parameter int ROW_B     = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld,
	input  m3i_pkg::mat_t  mat,
	output logic           out_vld,
	output m3i_pkg::mat_t  out_mat
);
	import m3i_pkg::*;

	localparam int MW = $bits(mat_t);
	localparam logic signed [63:0] RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;

	fx_t                num [1];
	fx_t                den [1];
	fx_t                x   [1];
	logic               dv;
	logic [MW-1:0]      dside;
	mat_t               dmat;

	logic               vld_s1;
	mat_t               mat_s1;
	logic signed [63:0] prod_s1 [0:5];
	logic               vld_s2;
	mat_t               mat_s2;

	assign num[0] = mat.t[ROW_A][ROW_B];
	assign den[0] = mat.t[ROW_B][ROW_B];

	m3i_div #(
		.FRAC_BITS (FRAC_BITS),
		.LANES     (1),
		.SIDE_W    (MW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (vld),
		.num      (num),
		.den      (den),
		.side     (mat),
		.out_vld  (dv),
		.quo      (x),
		.out_side (dside)
	);

	assign dmat = mat_t'(dside);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= dv;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat_s1 <= dmat;
			for (int j = 0; j < 3; j++) begin
				prod_s1[j]   <= x[0] * $signed(dmat.t[ROW_B][j]);
				prod_s1[j+3] <= x[0] * $signed(dmat.w[ROW_B][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat_t nm;
			nm = mat_s1;
			for (int j = 0; j < 6; j++) begin
				logic signed [63:0] p;
				logic signed [63:0] q;
				logic signed [63:0] v;
				p = prod_s1[j];
				q = (p + ((p < 0) ? RND : 64'sd0)) >>> FRAC_BITS;
				if (j < 3) begin
					v = 64'($signed(mat_s1.t[ROW_A][j]));
					nm.t[ROW_A][j] = sat64(v - q);
				end else begin
					v = 64'($signed(mat_s1.w[ROW_A][j-3]));
					nm.w[ROW_A][j-3] = sat64(v - q);
				end
			end
			mat_s2 <= nm;
		end
	end

	assign out_vld = vld_s2;
	assign out_mat = mat_s2;

endmodule

>>> src/m3i_scale.sv
// ----------------------------------------------------------------------------
// m3i_scale - final row scaling
// Divides each companion row by the working diagonal; a zero diagonal or an
// earlier failed swap flags singular and forces all nine results to zero.
// ----------------------------------------------------------------------------
module m3i_scale #(
	parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld,
	input  m3i_pkg::mat_t  mat,
	output logic           out_vld,
	output m3i_pkg::fx_t   inv [9],
	output logic           sing
);
	import m3i_pkg::*;

	logic sing_f;
	fx_t  num [9];
	fx_t  den [9];

	assign sing_f = mat.sing | (mat.t[0][0] == '0) | (mat.t[1][1] == '0)
	              | (mat.t[2][2] == '0);

	for (genvar l = 0; l < 9; l++) begin : g_lane
		assign num[l] = sing_f ? '0 : mat.w[l/3][l%3];
		assign den[l] = mat.t[l/3][l/3];
	end : g_lane

	m3i_div #(
		.FRAC_BITS (FRAC_BITS),
		.LANES     (9),
		.SIDE_W    (1)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (vld),
		.num      (num),
		.den      (den),
		.side     (sing_f),
		.out_vld  (out_vld),
		.quo      (inv),
		.out_side (sing)
	);

endmodule

>>> src/matrix3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3_inverse - pipelined 3x3 fixed-point matrix inverse
// Input channel in_valid/in_stall carries one matrix a11..a33 per word;
// output channel out_valid/out_stall carries inv11..inv33 and singular.
// A word is taken at a clock edge with valid high and stall low.
// Work: row-swap stage, six elimination units (divider, multiply,
// subtract), then a nine-lane final divider. Each divider resolves one
// quotient bit per stage, so it sets the depth.
// Throughput: one matrix per cycle while the receiver does not stall; no state carried between matrices.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises; nothing is dropped or repeated.
// Reset (arst_n low) clears all valid bits; the pipeline comes up empty.
// ----------------------------------------------------------------------------
module matrix3_inverse #(
	parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  m3i_pkg::fx_t  a11,
	input  m3i_pkg::fx_t  a12,
	input  m3i_pkg::fx_t  a13,
	input  m3i_pkg::fx_t  a21,
	input  m3i_pkg::fx_t  a22,
	input  m3i_pkg::fx_t  a23,
	input  m3i_pkg::fx_t  a31,
	input  m3i_pkg::fx_t  a32,
	input  m3i_pkg::fx_t  a33,
	output logic          out_valid,
	input  logic          out_stall,
	output m3i_pkg::fx_t  inv11,
	output m3i_pkg::fx_t  inv12,
	output m3i_pkg::fx_t  inv13,
	output m3i_pkg::fx_t  inv21,
	output m3i_pkg::fx_t  inv22,
	output m3i_pkg::fx_t  inv23,
	output m3i_pkg::fx_t  inv31,
	output m3i_pkg::fx_t  inv32,
	output m3i_pkg::fx_t  inv33,
	output logic          singular
);
	import m3i_pkg::*;

	localparam int ROW_A [6] = '{1, 2, 2, 1, 0, 0};
	localparam int ROW_B [6] = '{0, 0, 1, 2, 2, 1};

	logic en;
	fx_t  a [0:2][0:2];
	fx_t  inv [9];
	logic vld [0:6];
	mat_t mat [0:6];

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	assign a = '{'{a11, a12, a13}, '{a21, a22, a23}, '{a31, a32, a33}};

	m3i_pivot #(
		.FRAC_BITS (FRAC_BITS)
	) u_pivot (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (in_valid),
		.a       (a),
		.out_vld (vld[0]),
		.out_mat (mat[0])
	);

	for (genvar e = 0; e < 6; e++) begin : g_elim
		m3i_elim #(
			.FRAC_BITS (FRAC_BITS),
			.ROW_A     (ROW_A[e]),
			.ROW_B     (ROW_B[e])
		) u_elim (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld     (vld[e]),
			.mat     (mat[e]),
			.out_vld (vld[e+1]),
			.out_mat (mat[e+1])
		);
	end : g_elim

	m3i_scale #(
		.FRAC_BITS (FRAC_BITS)
	) u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (vld[6]),
		.mat     (mat[6]),
		.out_vld (out_valid),
		.inv     (inv),
		.sing    (singular)
	);

	assign inv11 = inv[0];
	assign inv12 = inv[1];
	assign inv13 = inv[2];
	assign inv21 = inv[3];
	assign inv22 = inv[4];
	assign inv23 = inv[5];
	assign inv31 = inv[6];
	assign inv32 = inv[7];
	assign inv33 = inv[8];

endmodule

>>> dv/matrix3_inverse_tb.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_tb - self-checking bench for the 3x3 matrix inverse
// Drives matrices through the valid/stall input channel with random idle
// bursts and checks every output word against a fixed-point Gauss-Jordan
// predictor. Covers extremes, swaps, singular cases and random matrices.
// ----------------------------------------------------------------------------
module matrix3_inverse_tb;

	import m3i_pkg::*;

	localparam int     FRAC     = FRAC_BITS_DEF;
	localparam longint ONE      = longint'(1) << FRAC;
	localparam longint WMAX     = 64'sd2147483647;
	localparam longint WMIN     = -64'sd2147483648;
	localparam int     LATENCY  = 7 * (32 + FRAC) + 27;
	localparam int     MAX_CYC  = 400000;

	typedef struct {
		fx_t  v[9];
		logic sing;
	} inverse_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	fx_t  a11, a12, a13, a21, a22, a23, a31, a32, a33;
	logic out_valid;
	logic out_stall;
	fx_t  inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32, inv33;
	logic singular;

	inverse_t exp_inverses[$];
	int       errors;
	int       sent;
	int       received;
	int       sing_seen;
	int       cycles;
	bit       quiet;

	matrix3_inverse i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a11(a11), .a12(a12), .a13(a13),
		.a21(a21), .a22(a22), .a23(a23),
		.a31(a31), .a32(a32), .a33(a33),
		.out_valid(out_valid), .out_stall(out_stall),
		.inv11(inv11), .inv12(inv12), .inv13(inv13),
		.inv21(inv21), .inv22(inv22), .inv23(inv23),
		.inv31(inv31), .inv32(inv32), .inv33(inv33),
		.singular(singular)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clip(longint v);
		if (v > WMAX) begin
			return WMAX;
		end
		if (v < WMIN) begin
			return WMIN;
		end
		return v;
	endfunction

	function automatic longint qdiv(longint n, longint d);
		if (d == 0) begin
			return 0;
		end
		return clip((n * ONE) / d);
	endfunction

	function automatic inverse_t invert(fx_t m[9]);
		longint   t[3][3];
		longint   w[3][3];
		longint   tmp;
		longint   x;
		int       partner;
		int       ra[6];
		int       rb[6];
		inverse_t res;
		ra = '{1, 2, 2, 1, 0, 0};
		rb = '{0, 0, 1, 2, 2, 1};
		res.sing = 1'b0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				t[r][c] = longint'(m[r*3+c]);
				w[r][c] = (r == c) ? ONE : 0;
			end
		end
		for (int c = 0; c < 3; c++) begin
			if (t[c][c] == 0) begin
				partner = -1;
				for (int k = 0; k < 3; k++) begin
					if (t[k][c] != 0) begin
						partner = k;
					end
				end
				if (partner < 0) begin
					res.sing = 1'b1;
				end else begin
					for (int j = 0; j < 3; j++) begin
						tmp = t[c][j]; t[c][j] = t[partner][j]; t[partner][j] = tmp;
						tmp = w[c][j]; w[c][j] = w[partner][j]; w[partner][j] = tmp;
					end
				end
			end
		end
		for (int e = 0; e < 6; e++) begin
			x = qdiv(t[ra[e]][rb[e]], t[rb[e]][rb[e]]);
			for (int j = 0; j < 3; j++) begin
				t[ra[e]][j] = clip(t[ra[e]][j] - (x * t[rb[e]][j]) / ONE);
			end
			for (int j = 0; j < 3; j++) begin
				w[ra[e]][j] = clip(w[ra[e]][j] - (x * w[rb[e]][j]) / ONE);
			end
		end
		for (int r = 0; r < 3; r++) begin
			if (t[r][r] == 0) begin
				res.sing = 1'b1;
			end
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				res.v[r*3+c] = res.sing ? '0 : fx_t'(qdiv(w[r][c], t[r][r]));
			end
		end
		return res;
	endfunction

	// accepted input words become expected inverses
	always @(posedge clk) begin
		fx_t m[9];
		if (arst_n && in_valid && !in_stall) begin
			m = '{a11, a12, a13, a21, a22, a23, a31, a32, a33};
			exp_inverses.push_back(invert(m));
		end
	end

	always @(posedge clk) begin
		fx_t      got[9];
		inverse_t e;
		if (arst_n && out_valid && !out_stall) begin
			got = '{inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32, inv33};
			received++;
			if (exp_inverses.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, actual singular %b", $time, singular);
			end else begin
				e = exp_inverses.pop_front();
				if (e.sing) begin
					sing_seen++;
				end
				for (int i = 0; i < 9; i++) begin
					if (got[i] !== e.v[i]) begin
						errors++;
						$display("%0t: inv%0d%0d expected %h actual %h", $time,
							i / 3 + 1, i % 3 + 1, e.v[i], got[i]);
					end
				end
				if (singular !== e.sing) begin
					errors++;
					$display("%0t: singular expected %b actual %b", $time, e.sing, singular);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYC) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver stall bursts
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 13);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_matrix(fx_t m[9]);
		int n;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 13);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		{a11, a12, a13, a21, a22, a23, a31, a32, a33} <=
			{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (exp_inverses.size() != 0) @(posedge clk);
	endtask

	function automatic fx_t rnd_around(int lim);
		return fx_t'($signed($urandom_range(0, 2 * lim)) - lim);
	endfunction

	task automatic test_directed();
		fx_t o;
		fx_t mx;
		fx_t mn;
		o  = fx_t'(ONE);
		mx = fx_t'(WMAX);
		mn = fx_t'(WMIN);
		send_matrix('{o, 0, 0, 0, o, 0, 0, 0, o});
		send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
		send_matrix('{mx, mx, mx, mx, mx, mx, mx, mx, mx});
		send_matrix('{mn, mn, mn, mn, mn, mn, mn, mn, mn});
		send_matrix('{mx, 0, 0, 0, mx, 0, 0, 0, mx});
		send_matrix('{mn, 0, 0, 0, mn, 0, 0, 0, mn});
		send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
		send_matrix('{-1, 0, 0, 0, 1, 0, 0, 0, -1});
		send_matrix('{2 * o, 0, 0, 0, -4 * o, 0, 0, 0, o / 2});
		// permutations: zero diagonals resolved by swaps
		send_matrix('{0, o, 0, o, 0, 0, 0, 0, o});
		send_matrix('{0, 0, o, 0, o, 0, o, 0, 0});
		send_matrix('{0, o, 0, 0, 0, o, o, 0, 0});
		// zero diagonal with candidate rows above and below it
		send_matrix('{o, 2 * o, 0, 0, 0, o, 0, o, 0});
		send_matrix('{0, o, o, o, 0, o, o, o, 0});
		// zero column, no partner
		send_matrix('{0, o, 2 * o, 0, 3 * o, o, 0, o, o});
		send_matrix('{o, 0, 2 * o, 3 * o, 0, o, o, 0, o});
		// dependent rows, zero final diagonal
		send_matrix('{o, 2 * o, 3 * o, o, 2 * o, 3 * o, 4 * o, 5 * o, 6 * o});
		send_matrix('{o, 2 * o, 3 * o, 4 * o, 5 * o, 6 * o, 7 * o, 8 * o, 9 * o});
		// overflow in intermediates and outputs
		send_matrix('{1, mx, mn, mn, 1, mx, mx, mn, 1});
		send_matrix('{mx, mn, mx, mn, mx, mn, mx, mn, -1});
		send_matrix('{2, 3, 5, 7, 11, 13, 17, 19, 23});
		send_matrix('{o, o / 2, o / 3, o / 2, o / 3, o / 4, o / 3, o / 4, o / 5});
	endtask

	task automatic test_dominant(int n);
		fx_t m[9];
		repeat (n) begin
			for (int i = 0; i < 9; i++) begin
				m[i] = rnd_around(int'(2 * ONE));
			end
			for (int d = 0; d < 3; d++) begin
				m[d*4] = fx_t'($urandom_range(32'(4 * ONE), 32'(8 * ONE)));
				if ($urandom_range(0, 1)) begin
					m[d*4] = -m[d*4];
				end
			end
			send_matrix(m);
		end
	endtask

	task automatic test_sparse(int n);
		fx_t m[9];
		repeat (n) begin
			for (int i = 0; i < 9; i++) begin
				m[i] = $urandom_range(0, 1) ? rnd_around(int'(4 * ONE)) : '0;
			end
			send_matrix(m);
		end
	endtask

	task automatic test_full_range(int n);
		fx_t m[9];
		repeat (n) begin
			for (int i = 0; i < 9; i++) begin
				m[i] = fx_t'($urandom);
			end
			send_matrix(m);
		end
	endtask

	task automatic test_dependent(int n);
		fx_t m[9];
		int  s;
		repeat (n) begin
			for (int i = 0; i < 9; i++) begin
				m[i] = rnd_around(int'(8 * ONE));
			end
			s = $urandom_range(0, 2);
			for (int j = 0; j < 3; j++) begin
				m[((s + 1) % 3) * 3 + j] = m[s * 3 + j];
			end
			send_matrix(m);
		end
	endtask

	task automatic test_mixed_tail(int n);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: test_dominant(1);
				1: test_sparse(1);
				2: test_full_range(1);
				default: test_dependent(1);
			endcase
		end
	endtask

	initial begin
		errors    = 0;
		sent      = 0;
		received  = 0;
		sing_seen = 0;
		cycles    = 0;
		quiet     = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		{a11, a12, a13, a21, a22, a23, a31, a32, a33} = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_dominant(400);
		wait_drained();
		test_sparse(300);
		test_full_range(250);
		test_dependent(150);
		quiet = 1'b1;
		test_mixed_tail(200);

		wait_drained();
		repeat (LATENCY + 20) @(posedge clk);
		if (exp_inverses.size() != 0) begin
			errors++;
			$display("%0t: %0d expected words never arrived", $time, exp_inverses.size());
		end
		$display("sent %0d matrices, checked %0d inverses, %0d singular", sent, received,
			sing_seen);
		$display("directed extremes, swaps, dependent rows and random matrices, %0d errors",
			errors);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> sim.f
src/m3i_pkg.sv
src/m3i_div.sv
src/m3i_pivot.sv
src/m3i_elim.sv
src/m3i_scale.sv
src/matrix3_inverse.sv
dv/matrix3_inverse_tb.sv
